@@ rtl/core/prr_pkg.sv @@
// types and constants shared by the polyphase resampler modules
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 18;
    localparam int PROD_W     = SAMPLE_W + COEFF_W;
    localparam int ACC_W      = 48;
    localparam int OUT_SHIFT  = 17;
    localparam int COEF_IDX_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int RATE_CFG_W = 5;
    localparam int FLEN_CFG_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLEN   = 2'd2;

    localparam logic [RATE_CFG_W-1:0] INTERP_RST = 5'd1;
    localparam logic [RATE_CFG_W-1:0] DECIM_RST  = 5'd1;
    localparam logic [FLEN_CFG_W-1:0] FLEN_RST   = 9'd64;

    // request kinds
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_COEFF  = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SHIFT = 8'b0000_0100,
        S_HEAD  = 8'b0000_1000,
        S_PHASE = 8'b0001_0000,
        S_MAC   = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } prr_state_t;

    typedef struct packed {
        logic clear;
        logic vld;
    } prr_mac_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/prr_mac.sv @@
// shared multiply-accumulate unit with output scaling and saturation
`timescale 1ns / 1ps
`default_nettype none

module prr_mac (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire prr_pkg::prr_mac_ctrl_t           ctrl,
    input  wire logic signed [prr_pkg::SAMPLE_W-1:0] dly,
    input  wire logic signed [prr_pkg::COEFF_W-1:0]  cof,
    output logic                                  busy,
    output logic signed [prr_pkg::SAMPLE_W-1:0]   result
);

    localparam int AccW = prr_pkg::ACC_W;
    localparam int ProdW = prr_pkg::PROD_W;
    localparam int SmpW = prr_pkg::SAMPLE_W;
    localparam int Shft = prr_pkg::OUT_SHIFT;

    logic signed [ProdW-1:0] prod_reg;
    logic                    prod_vld_reg;
    logic signed [AccW-1:0]  acc_reg;
    logic [AccW-1-(Shft+SmpW-1):0] top_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            prod_reg     <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.vld;
            if (ctrl.vld)
            begin
                prod_reg <= dly * cof;
            end
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + AccW'(prod_reg);
            end
        end
    end

    assign busy = prod_vld_reg;

    // floor shift is a plain slice, saturate when the upper bits disagree
    assign top_bits = acc_reg[AccW-1:Shft+SmpW-1];

    always_comb
    begin
        if (top_bits == '0 || top_bits == '1)
        begin
            result = acc_reg[Shft+SmpW-1:Shft];
        end
        else if (acc_reg[AccW-1])
        begin
            result = {1'b1, {(SmpW-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(SmpW-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/polyphase_rational_resampler_top.sv @@
// polyphase rational resampler, one branch, with sequencer and tap memories
//
// requests come in on in_valid/in_ready. action selects a coefficient write
// (coeff_index, coeff_value: no result) or a sample (sample_in,
// frame_end). a sample is shifted into the delay line and L phases run; each
// phase where the decimation counter is zero sends one result on
// out_valid/out_ready with out_sample, last_of_run and frame_end_out.
// one shared multiplier-accumulator and one delay memory with a read and a
// write port do all the work: a sample first shifts the delay line, then a
// dropped phase is skipped and a kept phase runs filter_length/L taps.
// the reset setting is 64 taps, L = M = 1. in_ready is low while a sample is
// in work. the result register lets the next kept phase be computed while the
// previous result waits; a stalled receiver holds the sequencer only at the
// point where a new result would be loaded.
// after reset all MAX_TAPS delay line entries are zeroed with in_ready low.
// the user writes registers on cfg_we/cfg_index/cfg_data only while idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module polyphase_rational_resampler_top #(
    parameter int MAX_TAPS = 256,
    parameter int MAX_RATE = 16
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    output logic                                    in_ready,
    input  wire logic                               action,
    input  wire logic signed [prr_pkg::SAMPLE_W-1:0]   sample_in,
    input  wire logic [prr_pkg::COEF_IDX_W-1:0]        coeff_index,
    input  wire logic signed [prr_pkg::COEFF_W-1:0]    coeff_value,
    input  wire logic                               frame_end,
    output logic                                    out_valid,
    input  wire                                     out_ready,
    output logic signed [prr_pkg::SAMPLE_W-1:0]     out_sample,
    output logic                                    last_of_run,
    output logic                                    frame_end_out,
    input  wire                                     cfg_we,
    input  wire logic [prr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [prr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int AW  = $clog2(MAX_TAPS);
    localparam int FW  = $clog2(MAX_TAPS + 1);
    localparam int RW  = $clog2(MAX_RATE + 1);
    localparam int PW  = $clog2(MAX_RATE);
    localparam int LW  = (RW > prr_pkg::RATE_CFG_W) ? RW : prr_pkg::RATE_CFG_W;
    localparam int FLW = (FW > prr_pkg::FLEN_CFG_W) ? FW : prr_pkg::FLEN_CFG_W;
    localparam int SW  = ((FW > RW) ? FW : RW) + 1;
    localparam int IW  = (AW > prr_pkg::COEF_IDX_W) ? AW : prr_pkg::COEF_IDX_W;
    localparam int SmpW = prr_pkg::SAMPLE_W;
    localparam int CofW = prr_pkg::COEFF_W;

    // configuration
    logic [prr_pkg::RATE_CFG_W-1:0] interp_reg;
    logic [prr_pkg::RATE_CFG_W-1:0] decim_reg;
    logic [prr_pkg::FLEN_CFG_W-1:0] flen_reg;

    logic [LW-1:0]  l_raw;
    logic [LW-1:0]  m_raw;
    logic [FLW-1:0] fl_raw;
    logic [RW-1:0]  l_eff;
    logic [RW-1:0]  m_eff;
    logic [FW-1:0]  fl_eff;

    // sequencer
    prr_pkg::prr_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] sh_addr_reg, sh_addr_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] dp_reg, dp_next;
    logic [AW-1:0] j_reg, j_next;
    logic [FW-1:0] base_reg, base_next;
    logic signed [SmpW-1:0] sample_reg, sample_next;
    logic frame_end_reg, frame_end_next;

    logic shift_rd_reg;
    logic mac_rd_reg;
    logic [AW-1:0] rd_addr_reg;

    logic out_valid_reg;
    logic signed [SmpW-1:0] out_sample_reg;
    logic last_reg;
    logic fe_out_reg;

    logic out_load;
    logic mac_issue;
    logic shift_issue;
    logic cof_we;
    logic idx_ok;
    logic [IW-1:0] cidx;

    logic [SW-1:0] base_sum;
    logic [SW-1:0] ci_full;
    logic          tap_more;
    logic          phase_last;
    logic          run_last;
    logic [PW-1:0] dp_adv;

    // memories
    logic signed [SmpW-1:0] dly_mem [MAX_TAPS];
    logic signed [CofW-1:0] cof_mem [MAX_TAPS];
    logic signed [SmpW-1:0] dly_q;
    logic signed [CofW-1:0] cof_q;
    logic                   dly_rd_en;
    logic [AW-1:0]          dly_ra;
    logic                   dly_we;
    logic [AW-1:0]          dly_wa;
    logic signed [SmpW-1:0] dly_wd;

    prr_pkg::prr_mac_ctrl_t mac_ctrl;
    logic                   mac_busy;
    logic signed [SmpW-1:0] mac_result;

    // effective factors
    assign l_raw  = LW'(interp_reg);
    assign m_raw  = LW'(decim_reg);
    assign fl_raw = FLW'(flen_reg);

    always_comb
    begin
        if (l_raw == '0)
        begin
            l_eff = RW'(1);
        end
        else if (l_raw > LW'(MAX_RATE))
        begin
            l_eff = RW'(MAX_RATE);
        end
        else
        begin
            l_eff = l_raw[RW-1:0];
        end

        if (m_raw == '0)
        begin
            m_eff = RW'(1);
        end
        else if (m_raw > LW'(MAX_RATE))
        begin
            m_eff = RW'(MAX_RATE);
        end
        else
        begin
            m_eff = m_raw[RW-1:0];
        end

        if (fl_raw > FLW'(MAX_TAPS))
        begin
            fl_eff = FW'(MAX_TAPS);
        end
        else
        begin
            fl_eff = fl_raw[FW-1:0];
        end
    end

    assign cidx   = IW'(coeff_index);
    assign idx_ok = 32'(coeff_index) < 32'(MAX_TAPS);

    // tap j runs while (j+1)*L <= fl, base holds j*L
    assign base_sum   = SW'(base_reg) + SW'(l_eff);
    assign tap_more   = base_sum <= SW'(fl_eff);
    assign ci_full    = SW'(base_reg) + SW'(p_reg);
    assign phase_last = (RW'(p_reg) + RW'(1)) == l_eff;
    // next kept phase is M phases on
    assign run_last   = ((RW + 1)'(p_reg) + (RW + 1)'(m_eff)) >= (RW + 1)'(l_eff);
    assign dp_adv     = ((RW'(dp_reg) + RW'(1)) >= m_eff) ? '0 : (dp_reg + PW'(1));

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        sh_addr_next   = sh_addr_reg;
        p_next         = p_reg;
        dp_next        = dp_reg;
        j_next         = j_reg;
        base_next      = base_reg;
        sample_next    = sample_reg;
        frame_end_next = frame_end_reg;
        out_load       = 1'b0;
        mac_issue      = 1'b0;
        shift_issue    = 1'b0;
        cof_we         = 1'b0;

        case (state_reg)
            prr_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == AW'(MAX_TAPS - 1))
                begin
                    state_next = prr_pkg::S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            prr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == prr_pkg::ACT_COEFF)
                    begin
                        cof_we = idx_ok;
                    end
                    else
                    begin
                        sample_next    = sample_in;
                        frame_end_next = frame_end;
                        if (fl_eff >= FW'(2))
                        begin
                            sh_addr_next = AW'(fl_eff - FW'(2));
                            state_next   = prr_pkg::S_SHIFT;
                        end
                        else
                        begin
                            state_next = prr_pkg::S_HEAD;
                        end
                    end
                end
            end
            prr_pkg::S_SHIFT:
            begin
                shift_issue = 1'b1;
                if (sh_addr_reg == '0)
                begin
                    state_next = prr_pkg::S_HEAD;
                end
                else
                begin
                    sh_addr_next = sh_addr_reg - AW'(1);
                end
            end
            prr_pkg::S_HEAD:
            begin
                // wait out the last shifted write before the head write
                if (!shift_rd_reg)
                begin
                    p_next     = '0;
                    state_next = prr_pkg::S_PHASE;
                end
            end
            prr_pkg::S_PHASE:
            begin
                if (dp_reg == '0)
                begin
                    j_next     = '0;
                    base_next  = '0;
                    state_next = prr_pkg::S_MAC;
                end
                else
                begin
                    dp_next = dp_adv;
                    if (phase_last)
                    begin
                        state_next = prr_pkg::S_IDLE;
                    end
                    else
                    begin
                        p_next = p_reg + PW'(1);
                    end
                end
            end
            prr_pkg::S_MAC:
            begin
                if (tap_more)
                begin
                    mac_issue = 1'b1;
                    j_next    = j_reg + AW'(1);
                    base_next = FW'(base_sum);
                end
                else
                begin
                    state_next = prr_pkg::S_DRAIN;
                end
            end
            prr_pkg::S_DRAIN:
            begin
                if (!mac_rd_reg && !mac_busy)
                begin
                    state_next = prr_pkg::S_EMIT;
                end
            end
            prr_pkg::S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    dp_next  = dp_adv;
                    if (phase_last)
                    begin
                        state_next = prr_pkg::S_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + PW'(1);
                        state_next = prr_pkg::S_PHASE;
                    end
                end
            end
            default:
            begin
                state_next = prr_pkg::S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == prr_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg     <= prr_pkg::INTERP_RST;
            decim_reg      <= prr_pkg::DECIM_RST;
            flen_reg       <= prr_pkg::FLEN_RST;
            state_reg      <= prr_pkg::S_CLEAR;
            clr_addr_reg   <= '0;
            sh_addr_reg    <= '0;
            p_reg          <= '0;
            dp_reg         <= '0;
            j_reg          <= '0;
            base_reg       <= '0;
            sample_reg     <= '0;
            frame_end_reg  <= 1'b0;
            shift_rd_reg   <= 1'b0;
            mac_rd_reg     <= 1'b0;
            rd_addr_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            last_reg       <= 1'b0;
            fe_out_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    prr_pkg::REG_INTERP: interp_reg <= cfg_data[prr_pkg::RATE_CFG_W-1:0];
                    prr_pkg::REG_DECIM:  decim_reg  <= cfg_data[prr_pkg::RATE_CFG_W-1:0];
                    prr_pkg::REG_FLEN:   flen_reg   <= cfg_data[prr_pkg::FLEN_CFG_W-1:0];
                    default:             ;
                endcase
            end
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            sh_addr_reg   <= sh_addr_next;
            p_reg         <= p_next;
            dp_reg        <= dp_next;
            j_reg         <= j_next;
            base_reg      <= base_next;
            sample_reg    <= sample_next;
            frame_end_reg <= frame_end_next;
            shift_rd_reg  <= shift_issue;
            mac_rd_reg    <= mac_issue;
            if (shift_issue)
            begin
                rd_addr_reg <= sh_addr_reg;
            end
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_sample_reg <= mac_result;
                last_reg       <= run_last;
                fe_out_reg     <= run_last & frame_end_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_sample    = out_sample_reg;
    assign last_of_run   = last_reg;
    assign frame_end_out = fe_out_reg;

    // delay memory port control
    assign dly_rd_en = shift_issue | mac_issue;
    assign dly_ra    = shift_issue ? sh_addr_reg : j_reg;

    always_comb
    begin
        dly_we = 1'b0;
        dly_wa = '0;
        dly_wd = '0;
        if (state_reg == prr_pkg::S_CLEAR)
        begin
            dly_we = 1'b1;
            dly_wa = clr_addr_reg;
        end
        else if (shift_rd_reg)
        begin
            dly_we = 1'b1;
            dly_wa = rd_addr_reg + AW'(1);
            dly_wd = dly_q;
        end
        else if (state_reg == prr_pkg::S_HEAD && fl_eff != '0)
        begin
            dly_we = 1'b1;
            dly_wd = sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            dly_mem[dly_wa] <= dly_wd;
        end
        if (dly_rd_en)
        begin
            dly_q <= dly_mem[dly_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cof_we)
        begin
            cof_mem[cidx[AW-1:0]] <= coeff_value;
        end
        if (mac_issue)
        begin
            cof_q <= cof_mem[ci_full[AW-1:0]];
        end
    end

    assign mac_ctrl.clear = (state_reg == prr_pkg::S_PHASE) && (dp_reg == '0);
    assign mac_ctrl.vld   = mac_rd_reg;

    prr_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .dly    (dly_q),
        .cof    (cof_q),
        .busy   (mac_busy),
        .result (mac_result)
    );

endmodule

`default_nettype wire

@@ rtl/core/prr_checker.sv @@
// port-level checks for the polyphase resampler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module prr_port_checks (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              in_valid,
    input wire                              in_ready,
    input wire logic                        action,
    input wire                              out_valid,
    input wire                              out_ready,
    input wire logic [prr_pkg::SAMPLE_W-1:0] out_sample,
    input wire logic                        last_of_run,
    input wire logic                        frame_end_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample)
            && $stable(last_of_run) && $stable(frame_end_out))
        else $error("stalled result changed");

    // delay line clear runs right after reset
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("request taken during delay clear");

    // a sample request starts a multi-cycle run
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == prr_pkg::ACT_SAMPLE |=> !in_ready)
        else $error("ready after sample request");

    // a coefficient write leaves in_ready high
    a_coeff_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == prr_pkg::ACT_COEFF |=> in_ready)
        else $error("coefficient write stalled");

    // frame marker only on the closing result of a run
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end_out |-> last_of_run)
        else $error("frame end without last of run");

endmodule

bind polyphase_rational_resampler_top prr_port_checks u_prr_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .last_of_run   (last_of_run),
    .frame_end_out (frame_end_out)
);

`default_nettype wire
